[rtl/packet_header_deframer_checker_defines.svh]
// Assertion macros for the deframer/checker RTL (used by phdc_parser).
`ifndef PACKET_HEADER_DEFRAMER_CHECKER_DEFINES_SVH
`define PACKET_HEADER_DEFRAMER_CHECKER_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define PHDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define PHDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/phdc_pkg.sv]
// Types and constants for the packet header deframer and checker.
package phdc_pkg;

    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned HeaderBytes = 13;
    localparam int unsigned IdxWidth    = 4;
    localparam int unsigned OutTdataW   = 96;
    localparam int unsigned OutFieldsW  = 90;

    // Header byte positions
    localparam logic [IdxWidth-1:0] IdxLen3    = 4'd0;
    localparam logic [IdxWidth-1:0] IdxLen2    = 4'd1;
    localparam logic [IdxWidth-1:0] IdxLen1    = 4'd2;
    localparam logic [IdxWidth-1:0] IdxLen0    = 4'd3;
    localparam logic [IdxWidth-1:0] IdxCommand = 4'd4;
    localparam logic [IdxWidth-1:0] IdxCheck1  = 4'd5;
    localparam logic [IdxWidth-1:0] IdxCheck0  = 4'd6;
    localparam logic [IdxWidth-1:0] IdxFlags   = 4'd7;
    localparam logic [IdxWidth-1:0] IdxSess3   = 4'd8;
    localparam logic [IdxWidth-1:0] IdxSess2   = 4'd9;
    localparam logic [IdxWidth-1:0] IdxSess1   = 4'd10;
    localparam logic [IdxWidth-1:0] IdxSess0   = 4'd11;
    localparam logic [IdxWidth-1:0] IdxLrc     = IdxWidth'(HeaderBytes - 1);

    typedef struct packed {
        logic        has_body_byte;
        logic [7:0]  body_byte;
        logic        packet_end;
        logic [7:0]  command_code;
        logic [7:0]  flag_bits;
        logic [31:0] session_ident;
        logic [31:0] payload_length;
        logic        sum_ok;
        logic        lrc_ok;
    } t_result;

endpackage

[rtl/phdc_in_stage.sv]
// Input register stage for the received byte stream.
module phdc_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [phdc_pkg::ByteWidth-1:0] s_axis_tdata,
    input  logic                          i_advance,
    output logic                          o_valid,
    output logic [phdc_pkg::ByteWidth-1:0] o_data
);
    import phdc_pkg::*;

    logic                 r_valid;
    logic [ByteWidth-1:0] r_data;

    assign s_axis_tready = !r_valid || i_advance;
    assign o_valid       = r_valid;
    assign o_data        = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_data <= s_axis_tdata;
        end
    end

endmodule

[rtl/phdc_parser.sv]
// Header parse, body pass-through and check logic for one byte per cycle.
`include "packet_header_deframer_checker_defines.svh"

module phdc_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [phdc_pkg::ByteWidth-1:0] i_data,
    output logic                          o_res_valid,
    output phdc_pkg::t_result             o_res
);
    import phdc_pkg::*;

    logic                r_in_body, n_in_body;
    logic [IdxWidth-1:0] r_hdr_idx, n_hdr_idx;
    logic [31:0]         r_length, n_length;
    logic [7:0]          r_command, n_command;
    logic [15:0]         r_check, n_check;
    logic [7:0]          r_flags, n_flags;
    logic [31:0]         r_session, n_session;
    logic                r_lrc_match, n_lrc_match;
    logic [31:0]         r_bytes_left, n_bytes_left;
    logic [15:0]         r_sum, n_sum;
    logic [7:0]          r_xor, n_xor;
    logic [7:0]          xor_base;

    always_comb begin
        n_in_body    = r_in_body;
        n_hdr_idx    = r_hdr_idx;
        n_length     = r_length;
        n_command    = r_command;
        n_check      = r_check;
        n_flags      = r_flags;
        n_session    = r_session;
        n_lrc_match  = r_lrc_match;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_xor        = r_xor;
        xor_base     = (r_hdr_idx == IdxLen3) ? 8'd0 : r_xor;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_valid) begin
            if (r_in_body) begin
                n_sum               = r_sum + {8'd0, i_data};
                n_bytes_left        = r_bytes_left - 32'd1;
                o_res_valid         = 1'b1;
                o_res.has_body_byte = 1'b1;
                o_res.body_byte     = i_data;
                if (n_bytes_left == 32'd0) begin
                    o_res.packet_end     = 1'b1;
                    o_res.command_code   = r_command;
                    o_res.flag_bits      = r_flags;
                    o_res.session_ident  = r_session;
                    o_res.payload_length = r_length;
                    o_res.sum_ok         = (n_sum == r_check);
                    o_res.lrc_ok         = r_lrc_match;
                    n_in_body            = 1'b0;
                    n_hdr_idx            = '0;
                end
            end else begin
                unique case (r_hdr_idx)
                    IdxLen3:    n_length = {i_data, 24'd0};
                    IdxLen2:    n_length = r_length | {8'd0, i_data, 16'd0};
                    IdxLen1:    n_length = r_length | {16'd0, i_data, 8'd0};
                    IdxLen0:    n_length = r_length | {24'd0, i_data};
                    IdxCommand: n_command = i_data;
                    IdxCheck1:  n_check = {i_data, 8'd0};
                    IdxCheck0:  n_check = r_check | {8'd0, i_data};
                    IdxFlags:   n_flags = i_data;
                    IdxSess3:   n_session = {i_data, 24'd0};
                    IdxSess2:   n_session = r_session | {8'd0, i_data, 16'd0};
                    IdxSess1:   n_session = r_session | {16'd0, i_data, 8'd0};
                    IdxSess0:   n_session = r_session | {24'd0, i_data};
                    default:    ;
                endcase

                if (r_hdr_idx < IdxLrc) begin
                    n_xor     = xor_base ^ i_data;
                    n_hdr_idx = r_hdr_idx + 4'd1;
                end else begin
                    n_lrc_match = (xor_base == i_data);
                    n_sum       = '0;
                    n_hdr_idx   = '0;
                    if (r_length == 32'd0) begin
                        o_res_valid          = 1'b1;
                        o_res.packet_end     = 1'b1;
                        o_res.command_code   = r_command;
                        o_res.flag_bits      = r_flags;
                        o_res.session_ident  = r_session;
                        o_res.payload_length = r_length;
                        o_res.sum_ok         = (r_check == 16'd0);
                        o_res.lrc_ok         = n_lrc_match;
                    end else begin
                        n_bytes_left = r_length;
                        n_in_body    = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body    <= 1'b0;
            r_hdr_idx    <= '0;
            r_length     <= '0;
            r_command    <= '0;
            r_check      <= '0;
            r_flags      <= '0;
            r_session    <= '0;
            r_lrc_match  <= 1'b0;
            r_bytes_left <= '0;
            r_sum        <= '0;
            r_xor        <= '0;
        end else begin
            r_in_body    <= n_in_body;
            r_hdr_idx    <= n_hdr_idx;
            r_length     <= n_length;
            r_command    <= n_command;
            r_check      <= n_check;
            r_flags      <= n_flags;
            r_session    <= n_session;
            r_lrc_match  <= n_lrc_match;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_xor        <= n_xor;
        end
    end

    `PHDC_ASSERT_IMP(a_body_idx_zero, i_clk, i_rst_n, r_in_body, r_hdr_idx == '0, "body phase with header index set")
    `PHDC_ASSERT_IMP(a_empty_res_ends, i_clk, i_rst_n, o_res_valid && !o_res.has_body_byte, o_res.packet_end, "result without body byte does not close packet")
    `PHDC_ASSERT_NEXT(a_last_body_exits, i_clk, i_rst_n, i_valid && r_in_body && r_bytes_left == 32'd1, !r_in_body && r_hdr_idx == '0, "last body byte did not return to header")

endmodule

[rtl/phdc_out_fifo.sv]
// Two-entry result queue that decouples the parser from output stalls.
module phdc_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  phdc_pkg::t_result i_wr_res,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output phdc_pkg::t_result o_res
);
    import phdc_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign rd_en   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_res;
        end
    end

endmodule

[rtl/packet_header_deframer_checker.sv]
// Top level of the packet header deframer and checker.
//
// Input: one byte of the packet stream per s_axis transaction. Each packet is
// a 13-byte big-endian header (length, command, check code, flags, session,
// LRC) followed by length body bytes.
// Output: one m_axis transaction per body byte, tuser set and the byte in
// tdata[7:0]. The transaction that closes a packet has tlast set and carries
// the header fields plus the body-sum and LRC checks. A packet of length zero
// closes with a single transaction on its LRC byte, tuser clear.
// Header bytes other than the LRC produce no output transaction.
// Path: an accepted byte enters the input register and is parsed once the
// output queue has room; its result, if any, goes to the two-entry output
// queue that drives m_axis.
// Throughput: one byte per cycle while the output queue is not full, set by the
// combinational parse step between input register and output queue.
// Reset: synchronous, active low; parser returns to header byte 0, queue empty.
// When m_axis stalls, the queue fills and s_axis_tready drops once both queue
// entries and the input register hold data; nothing is lost or reordered.
module packet_header_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // [7:0] body_byte, [15:8] command_code,
                                       // [23:16] flag_bits, [55:24] session_ident,
                                       // [87:56] payload_length, [88] sum_ok,
                                       // [89] lrc_ok, [95:90] zero
    output logic        m_axis_tuser,  // [0] has_body_byte
    output logic        m_axis_tlast   // packet_end
);
    import phdc_pkg::*;

    logic                 stg_valid;
    logic [ByteWidth-1:0] stg_data;
    logic                 advance;
    logic                 fifo_full;
    logic                 res_valid;
    t_result              res;
    t_result              out_res;

    assign advance = stg_valid && !fifo_full;

    phdc_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_advance     (advance),
        .o_valid       (stg_valid),
        .o_data        (stg_data)
    );

    phdc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_data      (stg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    phdc_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (res_valid),
        .i_wr_res (res),
        .o_full   (fifo_full),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (out_res)
    );

    assign m_axis_tdata = {(OutTdataW - OutFieldsW)'(0), out_res.lrc_ok, out_res.sum_ok,
                           out_res.payload_length, out_res.session_ident,
                           out_res.flag_bits, out_res.command_code, out_res.body_byte};
    assign m_axis_tuser = out_res.has_body_byte;
    assign m_axis_tlast = out_res.packet_end;

endmodule

[tb/tb.sv]
// Self-checking stream testbench for the packet header deframer and checker.
module tb;
    import phdc_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;           // [7:0] body_byte ... [89] lrc_ok
    logic        m_axis_tuser;           // [0] has_body_byte
    logic        m_axis_tlast;           // packet_end

    packet_header_deframer_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Parser shadow state
    logic                in_body;
    logic [IdxWidth-1:0] hdr_pos;
    logic [31:0]         len_acc;
    logic [7:0]          cmd_acc;
    logic [15:0]         check_acc;
    logic [7:0]          flags_acc;
    logic [31:0]         sess_acc;
    logic                lrc_good;
    logic [31:0]         bytes_remaining;
    logic [15:0]         body_sum;
    logic [7:0]          hdr_xor;

    t_result     pending_results[$];
    t_result     next_expected;
    logic [7:0]  body_buf[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned packets_closed = 0;
    int unsigned bad_sums = 0;
    int unsigned bad_lrcs = 0;
    int unsigned error_count = 0;
    int unsigned stall_cycles = 0;

    function automatic t_result close_packet(input t_result r);
        t_result c;
        c = r;
        c.packet_end     = 1'b1;
        c.command_code   = cmd_acc;
        c.flag_bits      = flags_acc;
        c.session_ident  = sess_acc;
        c.payload_length = len_acc;
        c.sum_ok         = (body_sum == check_acc);
        c.lrc_ok         = lrc_good;
        return c;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        if (in_body) begin
            body_sum = body_sum + 16'(b);
            r.has_body_byte = 1'b1;
            r.body_byte = b;
            bytes_remaining = bytes_remaining - 1;
            if (bytes_remaining == 0) begin
                r = close_packet(r);
                in_body = 1'b0;
                hdr_pos = '0;
            end
            pending_results.push_back(r);
        end else begin
            case (hdr_pos)
                IdxLen3: begin
                    hdr_xor = 8'h00;
                    len_acc = {b, 24'h0};
                end
                IdxLen2:    len_acc[23:16] = b;
                IdxLen1:    len_acc[15:8] = b;
                IdxLen0:    len_acc[7:0] = b;
                IdxCommand: cmd_acc = b;
                IdxCheck1:  check_acc = {b, 8'h00};
                IdxCheck0:  check_acc[7:0] = b;
                IdxFlags:   flags_acc = b;
                IdxSess3:   sess_acc = {b, 24'h0};
                IdxSess2:   sess_acc[23:16] = b;
                IdxSess1:   sess_acc[15:8] = b;
                IdxSess0:   sess_acc[7:0] = b;
                default: ;
            endcase
            if (hdr_pos != IdxLrc) begin
                hdr_xor = hdr_xor ^ b;
                hdr_pos = hdr_pos + 1'b1;
            end else begin
                lrc_good = (hdr_xor == b);
                body_sum = '0;
                hdr_pos = '0;
                if (len_acc == 0) begin
                    pending_results.push_back(close_packet(r));
                end else begin
                    bytes_remaining = len_acc;
                    in_body = 1'b1;
                end
            end
        end
    endtask

    // Starts and returns at a falling edge; tvalid stays high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        deframe_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_header(input logic [31:0] len, input logic [7:0] cmd,
                               input logic [15:0] check, input logic [7:0] flags,
                               input logic [31:0] sess, input logic [7:0] lrc_flip);
        logic [7:0] hdr[HeaderBytes];
        logic [7:0] x;
        hdr = '{len[31:24], len[23:16], len[15:8], len[7:0], cmd, check[15:8],
                check[7:0], flags, sess[31:24], sess[23:16], sess[15:8], sess[7:0],
                8'h00};
        x = 8'h00;
        for (int k = 0; k < HeaderBytes - 1; k++) x ^= hdr[k];
        hdr[HeaderBytes-1] = x ^ lrc_flip;
        for (int k = 0; k < HeaderBytes; k++) send_byte(hdr[k]);
    endtask

    // Body comes from body_buf; check_flip and lrc_flip corrupt the checks.
    task automatic send_packet(input logic [7:0] cmd, input logic [7:0] flags,
                               input logic [31:0] sess, input logic [15:0] check_flip,
                               input logic [7:0] lrc_flip);
        logic [15:0] s;
        s = '0;
        foreach (body_buf[k]) s += 16'(body_buf[k]);
        send_header(32'(body_buf.size()), cmd, s ^ check_flip, flags, sess, lrc_flip);
        foreach (body_buf[k]) send_byte(body_buf[k]);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        // zero-length packet, all-ones fields: sum check fails, LRC holds
        send_header(32'h0, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'h00);
        // one-byte body with correct sum, corrupted LRC
        body_buf.delete();
        body_buf.push_back(8'hFF);
        send_packet(8'h00, 8'h00, 32'h0, 16'h0, 8'h01);
    endtask

    task automatic test_sum_wrap();
        body_buf.delete();
        for (int k = 0; k < 300; k++) body_buf.push_back(8'hFF);
        send_packet(8'($urandom), 8'($urandom), $urandom, 16'h0, 8'h00);
    endtask

    task automatic test_random_packets(input int unsigned n_bytes);
        int unsigned first;
        int unsigned len;
        int unsigned pick;
        logic [15:0] check_flip;
        logic [7:0]  lrc_flip;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 10)      len = 0;
            else if (pick < 65) len = $urandom_range(8, 1);
            else if (pick < 95) len = $urandom_range(40, 9);
            else                len = $urandom_range(120, 41);
            body_buf.delete();
            for (int k = 0; k < len; k++) body_buf.push_back(8'($urandom));
            check_flip = ($urandom_range(99) < 15) ? 16'($urandom_range(65535, 1)) : 16'h0;
            lrc_flip   = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 1)) : 8'h00;
            send_packet(8'($urandom), 8'($urandom), $urandom, check_flip, lrc_flip);
        end
    endtask

    // Length is never reached, so this must be the last traffic of the run.
    task automatic test_unbounded_length();
        send_header({1'b1, 31'($urandom)}, 8'($urandom), 16'($urandom), 8'($urandom),
                    $urandom, 8'h00);
        for (int k = 0; k < 20; k++) send_byte(8'($urandom));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, tdata 0x%0h", m_axis_tdata);
                error_count++;
            end else begin
                next_expected = pending_results.pop_front();
                if (next_expected.packet_end) begin
                    packets_closed++;
                    if (!next_expected.sum_ok) bad_sums++;
                    if (!next_expected.lrc_ok) bad_lrcs++;
                end
                check_field("has_body_byte", 32'(next_expected.has_body_byte),
                            32'(m_axis_tuser));
                check_field("body_byte", 32'(next_expected.body_byte), 32'(m_axis_tdata[7:0]));
                check_field("packet_end", 32'(next_expected.packet_end), 32'(m_axis_tlast));
                check_field("command_code", 32'(next_expected.command_code),
                            32'(m_axis_tdata[15:8]));
                check_field("flag_bits", 32'(next_expected.flag_bits),
                            32'(m_axis_tdata[23:16]));
                check_field("session_ident", next_expected.session_ident,
                            m_axis_tdata[55:24]);
                check_field("payload_length", next_expected.payload_length,
                            m_axis_tdata[87:56]);
                check_field("sum_ok", 32'(next_expected.sum_ok), 32'(m_axis_tdata[88]));
                check_field("lrc_ok", 32'(next_expected.lrc_ok), 32'(m_axis_tdata[89]));
                check_field("tdata_pad", 32'h0, 32'(m_axis_tdata[95:90]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("[packet_header_deframer_checker] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        in_body = 1'b0;
        hdr_pos = '0;
        len_acc = '0;
        cmd_acc = '0;
        check_acc = '0;
        flags_acc = '0;
        sess_acc = '0;
        lrc_good = 1'b0;
        bytes_remaining = '0;
        body_sum = '0;
        hdr_xor = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 38;
        recv_idle_pct = 67;
        test_directed();
        test_random_packets(430);
        wait_results_drained();

        send_idle_pct = 67;
        recv_idle_pct = 38;
        test_sum_wrap();
        test_random_packets(430);
        wait_results_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_packets(430);
        test_unbounded_length();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("Sent %0d stream bytes, checked %0d results over %0d closed packets",
                 bytes_sent, results_seen, packets_closed);
        $display("(%0d with bad body sum, %0d with bad LRC), plus sum wrap and a huge length",
                 bad_sums, bad_lrcs);
        if (error_count == 0) begin
            $display("[packet_header_deframer_checker] OK");
        end else begin
            $display("[packet_header_deframer_checker] ERROR");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/phdc_pkg.sv
rtl/phdc_in_stage.sv
rtl/phdc_parser.sv
rtl/phdc_out_fifo.sv
rtl/packet_header_deframer_checker.sv
tb/tb.sv
